// ===== sv/itfd_pkg.sv =====
package itfd_pkg;

	localparam logic [7:0] HDR_A     = 8'h59;
	localparam logic [7:0] HDR_B     = 8'h53;
	localparam logic [7:0] EULER_ID  = 8'h40;
	localparam logic [7:0] QUAT_ID   = 8'h41;
	localparam logic [7:0] LEN_EULER = 8'd12;
	localparam logic [7:0] LEN_QUAT  = 8'd16;

	localparam int unsigned NUM_VALUES = 7;

	// Control from the frame sequencer to the TLV parser.
	typedef struct packed {
		logic       clear;
		logic       byte_en;
		logic [7:0] data;
		logic [7:0] remaining;
	} tlv_ctrl_t;

	// Captured values: pitch, roll, yaw, w, x, y, z; flag bit 0 Euler, bit 1 quaternion.
	typedef struct packed {
		logic [NUM_VALUES-1:0][31:0] vals;
		logic [1:0]                  flags;
	} capture_t;

	typedef struct packed {
		logic       status;
		logic [15:0] seq;
		capture_t   cap;
	} result_t;

endpackage

// ===== sv/itfd_tlv.sv =====
module itfd_tlv (
	input  logic               clk,
	input  logic               arst_n,
	input  itfd_pkg::tlv_ctrl_t ctrl,
	output itfd_pkg::capture_t cap
);

	localparam logic [1:0] BP_ID   = 2'd0;
	localparam logic [1:0] BP_LEN  = 2'd1;
	localparam logic [1:0] BP_DATA = 2'd2;

	logic [7:0]  bid_q;
	logic [7:0]  blen_q;
	logic [7:0]  bpos_q;
	logic [1:0]  bphase_q;
	logic        stop_q;
	logic [1:0]  flags_q;
	logic [31:0] vals_q [itfd_pkg::NUM_VALUES];

	logic       euler_hit;
	logic       quat_hit;
	logic [2:0] slot;
	logic [7:0] bpos_inc;
	logic       blk_done;
	logic       active;

	assign euler_hit = (bid_q == itfd_pkg::EULER_ID) && (blen_q == itfd_pkg::LEN_EULER);
	assign quat_hit  = (bid_q == itfd_pkg::QUAT_ID) && (blen_q == itfd_pkg::LEN_QUAT);
	// A matched block is at most sixteen bytes, so two bits of position pick the word.
	assign slot      = (quat_hit ? 3'd3 : 3'd0) + {1'b0, bpos_q[3:2]};
	assign bpos_inc  = bpos_q + 8'd1;
	assign blk_done  = bpos_inc >= blen_q;
	assign active    = ctrl.byte_en && !stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_q    <= '0;
			blen_q   <= '0;
			bpos_q   <= '0;
			bphase_q <= BP_ID;
			stop_q   <= 1'b0;
			flags_q  <= '0;
			for (int i = 0; i < itfd_pkg::NUM_VALUES; i++) begin
				vals_q[i] <= '0;
			end
		end else if (ctrl.clear) begin
			bid_q    <= '0;
			blen_q   <= '0;
			bpos_q   <= '0;
			bphase_q <= BP_ID;
			stop_q   <= 1'b0;
			flags_q  <= '0;
			for (int i = 0; i < itfd_pkg::NUM_VALUES; i++) begin
				vals_q[i] <= '0;
			end
		end else if (active) begin
			case (bphase_q)
				BP_ID: begin
					// An id byte with nothing after it in the payload is ignored.
					if (ctrl.remaining != 8'd0) begin
						bid_q    <= ctrl.data;
						bphase_q <= BP_LEN;
					end
				end
				BP_LEN: begin
					blen_q <= ctrl.data;
					bpos_q <= '0;
					if (ctrl.data > ctrl.remaining) begin
						stop_q <= 1'b1;
					end else if (ctrl.data == 8'd0) begin
						bphase_q <= BP_ID;
					end else begin
						bphase_q <= BP_DATA;
					end
				end
				BP_DATA: begin
					for (int i = 0; i < itfd_pkg::NUM_VALUES; i++) begin
						if ((euler_hit || quat_hit) && slot == 3'(i)) begin
							vals_q[i][{bpos_q[1:0], 3'b000} +: 8] <= ctrl.data;
						end
					end
					bpos_q <= bpos_inc;
					if (blk_done) begin
						flags_q  <= flags_q | {quat_hit, euler_hit};
						bphase_q <= BP_ID;
					end
				end
				default: begin
					bphase_q <= BP_ID;
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < itfd_pkg::NUM_VALUES; i++) begin
			cap.vals[i] = vals_q[i];
		end
		cap.flags = flags_q;
	end

`ifndef SYNTH
	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> (flags_q == 2'b00 && bphase_q == BP_ID && !stop_q))
		else $error("TLV parser not cleared at frame start");

	a_pos_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		bphase_q == BP_DATA |-> bpos_q < blen_q)
		else $error("block position beyond block length");

	a_stop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stop_q) |-> $past(ctrl.byte_en && bphase_q == BP_LEN))
		else $error("parsing stopped outside a length byte");
`endif

endmodule

// ===== sv/itfd_outreg.sv =====
module itfd_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  itfd_pkg::result_t res_d,
	input  logic              out_stall,
	output logic              out_valid,
	output itfd_pkg::result_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid || !out_stall))
		else $error("result register loaded while its request is stalled");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("loaded result not offered");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(res_q)))
		else $error("stalled result request changed");
`endif

endmodule

// ===== sv/imu_tlv_frame_deframer_unit.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    rx_byte
// output    out_valid / out_stall  status, seq_number, euler_seen, quat_seen, 7 values
//
// Each byte is registered on acceptance and processed from that register; one byte per cycle while in_stall is low.
// A result is loaded into the output register when the second checksum byte is processed from the input register.
// arst_n clears all sequencing state asynchronously; the block then hunts for a header.
// in_stall rises only while a result waits in the output register and the next registered
// byte is a second checksum byte, so a stalled output holds the input for at most that case.
module imu_tlv_frame_deframer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [15:0]        seq_number,
	output logic               euler_seen,
	output logic               quat_seen,
	output logic signed [31:0] pitch_micro,
	output logic signed [31:0] roll_micro,
	output logic signed [31:0] yaw_micro,
	output logic signed [31:0] qw_micro,
	output logic signed [31:0] qx_micro,
	output logic signed [31:0] qy_micro,
	output logic signed [31:0] qz_micro
);

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_SEQ_LO  = 3'd1;
	localparam logic [2:0] PH_SEQ_HI  = 3'd2;
	localparam logic [2:0] PH_LEN     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CK1     = 3'd5;
	localparam logic [2:0] PH_CK2     = 3'd6;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [2:0]  phase_q, phase_d;
	logic        saw_q, saw_d;
	logic [15:0] seq_q, seq_d;
	logic [7:0]  plen_q, plen_d;
	logic [7:0]  ppos_q, ppos_d;
	logic [7:0]  sum_lo_q, sum_lo_d;
	logic [7:0]  sum_hi_q, sum_hi_d;
	logic [7:0]  fcb_q, fcb_d;

	logic [7:0] lo_add;
	logic [7:0] hi_add;
	logic [7:0] ppos_inc;
	logic       out_free;
	logic       adv;
	logic       frame_start;

	itfd_pkg::tlv_ctrl_t ctrl;
	itfd_pkg::capture_t  cap;
	itfd_pkg::result_t   res_d;
	itfd_pkg::result_t   res_q;

	assign out_free    = !out_valid || !out_stall;
	assign adv         = valid_s1 && ((phase_q != PH_CK2) || out_free);
	assign in_stall    = valid_s1 && !adv;
	assign frame_start = adv && (phase_q == PH_HUNT) && saw_q && (byte_s1 == itfd_pkg::HDR_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign lo_add   = sum_lo_q + byte_s1;
	assign hi_add   = sum_hi_q + lo_add;
	assign ppos_inc = ppos_q + 8'd1;

	always_comb begin
		phase_d  = phase_q;
		saw_d    = saw_q;
		seq_d    = seq_q;
		plen_d   = plen_q;
		ppos_d   = ppos_q;
		sum_lo_d = sum_lo_q;
		sum_hi_d = sum_hi_q;
		fcb_d    = fcb_q;
		case (phase_q)
			PH_HUNT: begin
				if (frame_start) begin
					saw_d    = 1'b0;
					sum_lo_d = '0;
					sum_hi_d = '0;
					seq_d    = '0;
					plen_d   = '0;
					ppos_d   = '0;
					phase_d  = PH_SEQ_LO;
				end else begin
					saw_d = (byte_s1 == itfd_pkg::HDR_A);
				end
			end
			PH_SEQ_LO: begin
				seq_d    = {8'h00, byte_s1};
				sum_lo_d = lo_add;
				sum_hi_d = hi_add;
				phase_d  = PH_SEQ_HI;
			end
			PH_SEQ_HI: begin
				seq_d    = {byte_s1, seq_q[7:0]};
				sum_lo_d = lo_add;
				sum_hi_d = hi_add;
				phase_d  = PH_LEN;
			end
			PH_LEN: begin
				plen_d   = byte_s1;
				ppos_d   = '0;
				sum_lo_d = lo_add;
				sum_hi_d = hi_add;
				phase_d  = (byte_s1 == 8'd0) ? PH_CK1 : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				sum_lo_d = lo_add;
				sum_hi_d = hi_add;
				ppos_d   = ppos_inc;
				if (ppos_inc >= plen_q) begin
					phase_d = PH_CK1;
				end
			end
			PH_CK1: begin
				fcb_d   = byte_s1;
				phase_d = PH_CK2;
			end
			PH_CK2: begin
				phase_d = PH_HUNT;
				saw_d   = 1'b0;
			end
			default: begin
				phase_d = PH_HUNT;
				saw_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			saw_q    <= 1'b0;
			seq_q    <= '0;
			plen_q   <= '0;
			ppos_q   <= '0;
			sum_lo_q <= '0;
			sum_hi_q <= '0;
			fcb_q    <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			saw_q    <= saw_d;
			seq_q    <= seq_d;
			plen_q   <= plen_d;
			ppos_q   <= ppos_d;
			sum_lo_q <= sum_lo_d;
			sum_hi_q <= sum_hi_d;
			fcb_q    <= fcb_d;
		end
	end

	always_comb begin
		ctrl.clear     = frame_start;
		ctrl.byte_en   = adv && (phase_q == PH_PAYLOAD);
		ctrl.data      = byte_s1;
		// Bytes left in the payload after this one.
		ctrl.remaining = plen_q - ppos_q - 8'd1;
	end

	itfd_tlv u_tlv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cap    (cap)
	);

	always_comb begin
		res_d.status = (fcb_q != sum_lo_q) || (byte_s1 != sum_hi_q);
		res_d.seq    = seq_q;
		res_d.cap    = cap;
	end

	itfd_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && (phase_q == PH_CK2)),
		.res_d     (res_d),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign status      = res_q.status;
	assign seq_number  = res_q.seq;
	assign euler_seen  = res_q.cap.flags[0];
	assign quat_seen   = res_q.cap.flags[1];
	assign pitch_micro = $signed(res_q.cap.vals[0]);
	assign roll_micro  = $signed(res_q.cap.vals[1]);
	assign yaw_micro   = $signed(res_q.cap.vals[2]);
	assign qw_micro    = $signed(res_q.cap.vals[3]);
	assign qx_micro    = $signed(res_q.cap.vals[4]);
	assign qy_micro    = $signed(res_q.cap.vals[5]);
	assign qz_micro    = $signed(res_q.cap.vals[6]);

`ifndef SYNTH
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(adv && phase_q == PH_CK2))
		else $error("result raised without a second checksum byte");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == PH_CK2) |=> (phase_q == PH_HUNT && !saw_q))
		else $error("header hunt not restarted after frame end");

	a_payload_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> ppos_q < plen_q)
		else $error("payload position beyond payload length");
`endif

endmodule

// ===== dv/tb_imu_tlv_frame_deframer_unit.sv =====
module tb_imu_tlv_frame_deframer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_TARGET  = 1800;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 10;
	localparam int REPORT_MAX   = 10;

	typedef enum logic [2:0] {
		FR_HUNT, FR_SEQ_LO, FR_SEQ_HI, FR_LEN, FR_PAYLOAD, FR_CK1, FR_CK2
	} frame_phase_e;

	typedef enum logic [1:0] {BLK_ID, BLK_LEN, BLK_DATA} block_phase_e;

	class deframe_scoreboard;
		frame_phase_e       phase;
		block_phase_e       blk_phase;
		logic               armed;
		logic [15:0]        seq;
		logic [7:0]         plen, ppos, sum_lo, sum_hi, ck_first;
		logic [7:0]         blk_id, blk_len, blk_pos;
		logic               stopped;
		itfd_pkg::capture_t cap;
		itfd_pkg::result_t  pending_q[$];
		int                 predicted, mismatches, frames, bad_frames, euler_frames, quat_frames;

		function new();
			clear_frame();
			phase = FR_HUNT;
		endfunction

		function void clear_frame();
			armed     = 1'b0;
			seq       = '0;
			plen      = '0;
			ppos      = '0;
			sum_lo    = '0;
			sum_hi    = '0;
			blk_id    = '0;
			blk_len   = '0;
			blk_pos   = '0;
			blk_phase = BLK_ID;
			stopped   = 1'b0;
			cap       = '0;
		endfunction

		function void add_sum(logic [7:0] b);
			sum_lo = sum_lo + b;
			sum_hi = sum_hi + sum_lo;
		endfunction

		// Advances the frame state by one accepted byte and queues the result it closes.
		function void note_byte(logic [7:0] b);
			int                remaining;
			int                base;
			int                slot;
			logic [1:0]        flag;
			itfd_pkg::result_t res;
			case (phase)
			FR_SEQ_LO: begin
				seq = {8'h00, b};
				add_sum(b);
				phase = FR_SEQ_HI;
			end
			FR_SEQ_HI: begin
				seq[15:8] = b;
				add_sum(b);
				phase = FR_LEN;
			end
			FR_LEN: begin
				plen = b;
				ppos = '0;
				add_sum(b);
				phase = (b == 8'h00) ? FR_CK1 : FR_PAYLOAD;
			end
			FR_PAYLOAD: begin
				add_sum(b);
				remaining = int'(plen) - int'(ppos) - 1;
				if (!stopped) begin
					case (blk_phase)
					BLK_ID: begin
						// An id byte with nothing after it is dropped.
						if (remaining >= 1) begin
							blk_id    = b;
							blk_phase = BLK_LEN;
						end
					end
					BLK_LEN: begin
						blk_len = b;
						blk_pos = '0;
						if (int'(b) > remaining)
							stopped = 1'b1;
						else if (b == 8'h00)
							blk_phase = BLK_ID;
						else
							blk_phase = BLK_DATA;
					end
					default: begin
						base = -1;
						flag = 2'b00;
						if (blk_id == itfd_pkg::EULER_ID && blk_len == itfd_pkg::LEN_EULER) begin
							base = 0;
							flag = 2'b01;
						end else if (blk_id == itfd_pkg::QUAT_ID &&
							blk_len == itfd_pkg::LEN_QUAT) begin
							base = 3;
							flag = 2'b10;
						end
						if (base >= 0) begin
							slot = base + int'(blk_pos) / 4;
							cap.vals[slot][8 * (int'(blk_pos) % 4) +: 8] = b;
						end
						blk_pos = blk_pos + 8'd1;
						if (blk_pos >= blk_len) begin
							cap.flags = cap.flags | flag;
							blk_phase = BLK_ID;
						end
					end
					endcase
				end
				ppos = ppos + 8'd1;
				if (ppos >= plen)
					phase = FR_CK1;
			end
			FR_CK1: begin
				ck_first = b;
				phase = FR_CK2;
			end
			FR_CK2: begin
				res.status = (ck_first != sum_lo) || (b != sum_hi);
				res.seq    = seq;
				res.cap    = cap;
				pending_q  = {pending_q, res};
				predicted++;
				phase = FR_HUNT;
				armed = 1'b0;
			end
			default: begin
				if (armed && b == itfd_pkg::HDR_B) begin
					clear_frame();
					phase = FR_SEQ_LO;
				end else begin
					armed = (b == itfd_pkg::HDR_A);
				end
			end
			endcase
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch on %s: expected %h, got %h", field, want, got);
		endfunction

		function void check_result(itfd_pkg::result_t got);
			itfd_pkg::result_t want;
			string names[itfd_pkg::NUM_VALUES] = '{"pitch", "roll", "yaw", "qw", "qx", "qy", "qz"};
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result with sequence %h arrived with none outstanding", got.seq);
				return;
			end
			want = pending_q[0];
			pending_q.delete(0);
			frames++;
			if (want.status)
				bad_frames++;
			if (want.cap.flags[0])
				euler_frames++;
			if (want.cap.flags[1])
				quat_frames++;
			if (want.status !== got.status)
				report("status", 32'(want.status), 32'(got.status));
			if (want.seq !== got.seq)
				report("seq_number", 32'(want.seq), 32'(got.seq));
			if (want.cap.flags[0] !== got.cap.flags[0])
				report("euler_seen", 32'(want.cap.flags[0]), 32'(got.cap.flags[0]));
			if (want.cap.flags[1] !== got.cap.flags[1])
				report("quat_seen", 32'(want.cap.flags[1]), 32'(got.cap.flags[1]));
			for (int i = 0; i < itfd_pkg::NUM_VALUES; i++) begin
				if (want.cap.vals[i] !== got.cap.vals[i])
					report(names[i], want.cap.vals[i], got.cap.vals[i]);
			end
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b1;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte   = 8'h00;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               status;
	logic [15:0]        seq_number;
	logic               euler_seen;
	logic               quat_seen;
	logic signed [31:0] pitch_micro, roll_micro, yaw_micro;
	logic signed [31:0] qw_micro, qx_micro, qy_micro, qz_micro;

	logic               hold_off  = 1'b0;
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 bytes_sent     = 0;
	int                 cycle_count    = 0;
	logic [7:0]         tx_q[$];
	logic [7:0]         pl_q[$];
	deframe_scoreboard  sb;

	imu_tlv_frame_deframer_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.seq_number  (seq_number),
		.euler_seen  (euler_seen),
		.quat_seen   (quat_seen),
		.pitch_micro (pitch_micro),
		.roll_micro  (roll_micro),
		.yaw_micro   (yaw_micro),
		.qw_micro    (qw_micro),
		.qx_micro    (qx_micro),
		.qy_micro    (qy_micro),
		.qz_micro    (qz_micro)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: sample the values from before the edge, then choose the next stall.
	always @(posedge clk) begin
		itfd_pkg::result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status       = status;
			got.seq          = seq_number;
			got.cap.flags    = {quat_seen, euler_seen};
			got.cap.vals[0]  = pitch_micro;
			got.cap.vals[1]  = roll_micro;
			got.cap.vals[2]  = yaw_micro;
			got.cap.vals[3]  = qw_micro;
			got.cap.vals[4]  = qx_micro;
			got.cap.vals[5]  = qy_micro;
			got.cap.vals[6]  = qz_micro;
			sb.check_result(got);
		end
		out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic send_queued();
		logic [7:0] b;
		while (tx_q.size() > 0) begin
			b = tx_q[0];
			tx_q.delete(0);
			while ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			rx_byte  <= b;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			sb.note_byte(b);
			bytes_sent++;
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'h0000_0000;
		3: return 32'hFFFF_FFFF;
		default: return $urandom();
		endcase
	endfunction

	function automatic void add_word(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			pl_q = {pl_q, w[8 * i +: 8]};
	endfunction

	function automatic void add_block(logic [7:0] id, logic [7:0] len);
		logic [31:0] w;
		pl_q = {pl_q, id, len};
		for (int i = 0; i < int'(len); i++) begin
			if (i % 4 == 0)
				w = pick_value();
			pl_q = {pl_q, w[8 * (i % 4) +: 8]};
		end
	endfunction

	// Fills the payload with a random mix of blocks up to exactly target bytes.
	function automatic void build_payload(int target);
		int         room;
		int         pick;
		logic [7:0] id;
		pl_q.delete();
		while (pl_q.size() < target) begin
			room = target - pl_q.size();
			if (room == 1) begin
				id = ($urandom_range(0, 1) == 0) ? itfd_pkg::QUAT_ID : 8'($urandom_range(0, 255));
				pl_q = {pl_q, id};
				break;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 2 && room >= 14) begin
				add_block(itfd_pkg::EULER_ID, itfd_pkg::LEN_EULER);
			end else if (pick <= 4 && room >= 18) begin
				add_block(itfd_pkg::QUAT_ID, itfd_pkg::LEN_QUAT);
			end else if (pick == 5 && room >= 18) begin
				if ($urandom_range(0, 1) == 0)
					add_block(itfd_pkg::EULER_ID, itfd_pkg::LEN_QUAT);
				else
					add_block(itfd_pkg::QUAT_ID, itfd_pkg::LEN_EULER);
			end else if (pick == 6) begin
				// The length runs past the end of the payload.
				case ($urandom_range(0, 2))
				0: id = itfd_pkg::EULER_ID;
				1: id = itfd_pkg::QUAT_ID;
				default: id = 8'($urandom_range(0, 255));
				endcase
				pl_q = {pl_q, id, 8'($urandom_range(room - 1, 255))};
				while (pl_q.size() < target)
					pl_q = {pl_q, 8'($urandom_range(0, 255))};
			end else if (pick == 7) begin
				add_block(8'($urandom_range(0, 255)), 8'd0);
			end else begin
				add_block(8'($urandom_range(0, 255)),
					8'($urandom_range(0, (room - 2 < 20) ? room - 2 : 20)));
			end
		end
	endfunction

	// Frames the current payload; ck_err bit 0 spoils the first check byte, bit 1 the second.
	function automatic void queue_frame(logic [15:0] seq, int len_byte, int ck_err);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] body[$];
		lo   = '0;
		hi   = '0;
		body = {seq[7:0], seq[15:8], 8'(len_byte)};
		body = {body, pl_q};
		foreach (body[i]) begin
			lo = lo + body[i];
			hi = hi + lo;
		end
		if (ck_err[0])
			lo = lo ^ 8'($urandom_range(1, 255));
		if (ck_err[1])
			hi = hi ^ 8'($urandom_range(1, 255));
		tx_q = {tx_q, itfd_pkg::HDR_A, itfd_pkg::HDR_B};
		tx_q = {tx_q, body};
		tx_q = {tx_q, lo, hi};
	endfunction

	function automatic void queue_noise(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
			0, 1: tx_q = {tx_q, itfd_pkg::HDR_A};
			2: tx_q = {tx_q, itfd_pkg::HDR_B};
			default: tx_q = {tx_q, 8'($urandom_range(0, 255))};
			endcase
		end
	endfunction

	initial begin
		int start;
		int ph;
		int kind;
		int target;
		bit held;
		arst_n <= 1'b0;
		sb   = new();
		held = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// A header broken by another byte, a run of header bytes, then an empty frame.
		tx_q = {itfd_pkg::HDR_A, 8'h00, itfd_pkg::HDR_B, itfd_pkg::HDR_A, itfd_pkg::HDR_A};
		pl_q.delete();
		queue_frame(16'hFFFF, 0, 0);
		// Both block kinds carrying the extreme values.
		pl_q = {itfd_pkg::EULER_ID, itfd_pkg::LEN_EULER};
		add_word(32'h7FFF_FFFF);
		add_word(32'h8000_0000);
		add_word(32'hFFFF_FFFF);
		pl_q = {pl_q, itfd_pkg::QUAT_ID, itfd_pkg::LEN_QUAT};
		add_word(32'h0000_0000);
		add_word(32'h0000_0001);
		add_word(32'h8000_0000);
		add_word(32'h7FFF_FFFF);
		queue_frame(16'h0000, pl_q.size(), 0);
		// Skipped blocks ahead of a valid one, and an id byte left alone at the end.
		pl_q.delete();
		add_block(itfd_pkg::EULER_ID, itfd_pkg::LEN_QUAT);
		add_block(itfd_pkg::QUAT_ID, 8'd0);
		add_block(8'hFF, 8'd3);
		add_block(itfd_pkg::EULER_ID, itfd_pkg::LEN_EULER);
		pl_q = {pl_q, itfd_pkg::QUAT_ID};
		queue_frame(16'h1234, pl_q.size(), 0);
		// A quaternion block, a repeated Euler block, an overrun hiding a valid-looking one.
		pl_q.delete();
		add_block(itfd_pkg::QUAT_ID, itfd_pkg::LEN_QUAT);
		add_block(itfd_pkg::EULER_ID, itfd_pkg::LEN_EULER);
		add_block(itfd_pkg::EULER_ID, itfd_pkg::LEN_EULER);
		pl_q = {pl_q, itfd_pkg::QUAT_ID, 8'd20};
		add_block(itfd_pkg::EULER_ID, itfd_pkg::LEN_EULER);
		queue_frame(16'h8000, pl_q.size(), 1);
		// Overrun on the very first block; the second check byte is wrong.
		pl_q = {itfd_pkg::EULER_ID, 8'hFF};
		queue_frame(16'h0001, 2, 2);
		send_queued();

		start = bytes_sent;
		while (bytes_sent < start + BYTE_TARGET) begin
			ph = (bytes_sent - start) * 4 / BYTE_TARGET;
			if (ph > 3)
				ph = 3;
			case (ph)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
			default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			// While requests flow freely, hold the result side off long enough to back up.
			if (ph == 0 && !held) begin
				held = 1'b1;
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			kind   = $urandom_range(0, 99);
			target = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 255) : $urandom_range(0, 40);
			build_payload(target);
			if (kind < 75) begin
				queue_noise($urandom_range(0, 2));
				queue_frame(16'($urandom()), pl_q.size(), 0);
			end else if (kind < 85) begin
				queue_frame(16'($urandom()), pl_q.size(), $urandom_range(1, 3));
			end else if (kind < 90) begin
				queue_frame(16'($urandom()), $urandom_range(0, 255), 0);
			end else begin
				queue_noise($urandom_range(1, 24));
			end
			send_queued();
		end
		in_valid <= 1'b0;

		while (sb.pending_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d bytes sent over four idling mixes and one long result hold-off;",
			bytes_sent);
		$display("%0d frames checked: %0d with bad checksums, %0d with Euler, %0d with quaternion",
			sb.frames, sb.bad_frames, sb.euler_frames, sb.quat_frames);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.mismatches,
				sb.pending_q.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/itfd_pkg.sv
sv/itfd_tlv.sv
sv/itfd_outreg.sv
sv/imu_tlv_frame_deframer_unit.sv
dv/tb_imu_tlv_frame_deframer_unit.sv
